/* sv/addressed_actuator_command_decoder_assert.svh */
// ----------------------------------------------------------------------------
// Addressed actuator command decoder assertion macros
// Shared concurrent assertion forms used by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ADDRESSED_ACTUATOR_COMMAND_DECODER_ASSERT_SVH
`define ADDRESSED_ACTUATOR_COMMAND_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define ACD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("acd assertion failed");

// Next-cycle implication, disabled during reset
`define ACD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("acd assertion failed");

`endif

/* sv/acd_pkg.sv */
// ----------------------------------------------------------------------------
// Addressed actuator command decoder package
// Widths, command codes, register indexes and shared structs.
// ----------------------------------------------------------------------------
package acd_pkg;

   localparam int BYTE_W   = 8;
   localparam int ADDR_W   = 6;
   localparam int PARAM_W  = 7;
   localparam int DUR_W    = 16;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 16;

   // Result action codes
   typedef enum logic [1:0] {
      ACT_STRIKE = 2'd0,
      ACT_DAMP   = 2'd1,
      ACT_SAVE   = 2'd2,
      ACT_COMMIT = 2'd3
   } action_type;

   // Parameter select codes (mode 1)
   localparam logic [PARAM_W-1:0] PARAM_NONE   = 7'h00;
   localparam logic [PARAM_W-1:0] PARAM_BASE   = 7'h01;
   localparam logic [PARAM_W-1:0] PARAM_SCALE  = 7'h02;
   localparam logic [PARAM_W-1:0] PARAM_ADDR   = 7'h03;
   localparam logic [PARAM_W-1:0] PARAM_COMMIT = 7'h7F;

   localparam logic [DUR_W-1:0] SCALE_OFFSET = 16'h0018;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STORED_ADDRESS     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STORED_SETUP_DONE  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STORED_STRIKE_BASE = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STORED_STRIKE_SCALE = 8'd3;

   // Working-state reload from the stored registers
   typedef struct packed {
      logic              load;
      logic [ADDR_W-1:0] node_address;
      logic              address_locked;
      logic [DUR_W-1:0]  strike_base;
      logic [DUR_W-1:0]  strike_scale;
   } load_type;

   // One result item
   typedef struct packed {
      action_type        action;
      logic [DUR_W-1:0]  duration;
      logic [ADDR_W-1:0] saved_address;
      logic [DUR_W-1:0]  commit_base;
      logic [DUR_W-1:0]  commit_scale;
   } result_type;

endpackage

/* sv/acd_csr.sv */
// ----------------------------------------------------------------------------
// Addressed actuator command decoder configuration registers
// Holds stored values; a known-index write issues a working-state reload.
// ----------------------------------------------------------------------------
module acd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [acd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [acd_pkg::CSR_DAT_W-1:0]  csr_data,
   output acd_pkg::load_type              load
);

   logic [acd_pkg::ADDR_W-1:0] stored_address_ff, stored_address_in;
   logic                       stored_setup_done_ff, stored_setup_done_in;
   logic [acd_pkg::DUR_W-1:0]  stored_strike_base_ff, stored_strike_base_in;
   logic [acd_pkg::DUR_W-1:0]  stored_strike_scale_ff, stored_strike_scale_in;
   logic                       write_hit;

   assign csr_ready = 1'b1;

   // Register decode; unknown indexes are dropped
   always_comb begin
      stored_address_in      = stored_address_ff;
      stored_setup_done_in   = stored_setup_done_ff;
      stored_strike_base_in  = stored_strike_base_ff;
      stored_strike_scale_in = stored_strike_scale_ff;
      write_hit              = 1'b0;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            acd_pkg::CSR_STORED_ADDRESS: begin
               stored_address_in = csr_data[acd_pkg::ADDR_W-1:0];
               write_hit         = 1'b1;
            end
            acd_pkg::CSR_STORED_SETUP_DONE: begin
               stored_setup_done_in = csr_data[0];
               write_hit            = 1'b1;
            end
            acd_pkg::CSR_STORED_STRIKE_BASE: begin
               stored_strike_base_in = csr_data;
               write_hit             = 1'b1;
            end
            acd_pkg::CSR_STORED_STRIKE_SCALE: begin
               stored_strike_scale_in = csr_data;
               write_hit              = 1'b1;
            end
            default: begin
               write_hit = 1'b0;
            end
         endcase
      end
   end

   // Reload values follow the updated store
   always_comb begin
      load.load           = write_hit;
      load.address_locked = stored_setup_done_in;
      load.node_address   = stored_setup_done_in ? stored_address_in : '0;
      load.strike_base    = stored_strike_base_in;
      load.strike_scale   = stored_strike_scale_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_address_ff      <= '0;
         stored_setup_done_ff   <= 1'b0;
         stored_strike_base_ff  <= '0;
         stored_strike_scale_ff <= '0;
      end else begin
         stored_address_ff      <= stored_address_in;
         stored_setup_done_ff   <= stored_setup_done_in;
         stored_strike_base_ff  <= stored_strike_base_in;
         stored_strike_scale_ff <= stored_strike_scale_in;
      end
   end

endmodule

/* sv/acd_core.sv */
// ----------------------------------------------------------------------------
// Addressed actuator command decoder core
// Input byte register, decoder state and single-pass command decode.
// ----------------------------------------------------------------------------
`include "addressed_actuator_command_decoder_assert.svh"

module acd_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [acd_pkg::BYTE_W-1:0]  req_rx_byte,
   input  acd_pkg::load_type           load,
   input  logic                        out_free,
   output logic                        res_valid,
   output acd_pkg::result_type         res
);

   logic                         in_valid_ff, in_valid_in;
   logic [acd_pkg::BYTE_W-1:0]   in_byte_ff;

   logic [acd_pkg::ADDR_W-1:0]   header_address_ff, header_address_in;
   logic                         header_mode_ff, header_mode_in;
   logic [acd_pkg::PARAM_W-1:0]  pending_parameter_ff, pending_parameter_in;
   logic [acd_pkg::ADDR_W-1:0]   node_address_ff, node_address_in;
   logic                         address_locked_ff, address_locked_in;
   logic [acd_pkg::DUR_W-1:0]    strike_base_ff, strike_base_in;
   logic [acd_pkg::DUR_W-1:0]    strike_scale_ff, strike_scale_in;

   logic [acd_pkg::ADDR_W-1:0]   v6;
   logic [acd_pkg::PARAM_W-1:0]  v7;
   logic [acd_pkg::DUR_W-1:0]    strike_product;
   logic                         has_result;
   logic                         advance;
   acd_pkg::result_type          decoded;

   assign v6 = in_byte_ff[acd_pkg::ADDR_W-1:0];
   assign v7 = in_byte_ff[acd_pkg::PARAM_W-1:0];

   // Product wraps to 16 bits, same as the final sum
   assign strike_product = 16'({10'd0, v6} * strike_scale_ff);

   // Byte decode against current state
   always_comb begin
      header_address_in    = header_address_ff;
      header_mode_in       = header_mode_ff;
      pending_parameter_in = pending_parameter_ff;
      node_address_in      = node_address_ff;
      address_locked_in    = address_locked_ff;
      strike_base_in       = strike_base_ff;
      strike_scale_in      = strike_scale_ff;
      has_result           = 1'b0;
      decoded              = '0;

      if (in_byte_ff[7]) begin
         // header latches target and mode and clears the pending parameter
         header_address_in    = v6;
         header_mode_in       = in_byte_ff[6];
         pending_parameter_in = acd_pkg::PARAM_NONE;
      end else if (header_address_ff == node_address_ff) begin
         if (!header_mode_ff) begin
            has_result = 1'b1;
            if (in_byte_ff[6]) begin
               decoded.action   = acd_pkg::ACT_DAMP;
               decoded.duration = {6'd0, v6, 4'd0};
            end else begin
               decoded.action   = acd_pkg::ACT_STRIKE;
               decoded.duration = strike_base_ff + strike_product;
            end
         end else if (pending_parameter_ff == acd_pkg::PARAM_NONE) begin
            pending_parameter_in = v7;
         end else begin
            unique case (pending_parameter_ff)
               acd_pkg::PARAM_BASE: begin
                  strike_base_in = {5'd0, v7, 4'd0};
               end
               acd_pkg::PARAM_SCALE: begin
                  strike_scale_in = {8'd0, v7, 1'b0} + acd_pkg::SCALE_OFFSET;
               end
               acd_pkg::PARAM_ADDR: begin
                  if (!address_locked_ff) begin
                     node_address_in       = v6;
                     address_locked_in     = 1'b1;
                     has_result            = 1'b1;
                     decoded.action        = acd_pkg::ACT_SAVE;
                     decoded.saved_address = v6;
                  end
               end
               acd_pkg::PARAM_COMMIT: begin
                  has_result           = 1'b1;
                  decoded.action       = acd_pkg::ACT_COMMIT;
                  decoded.commit_base  = strike_base_ff;
                  decoded.commit_scale = strike_scale_ff;
               end
               default: begin
                  has_result = 1'b0;
               end
            endcase
         end
      end
   end

   // Byte leaves the input register unless its result has nowhere to go
   assign advance   = in_valid_ff && (out_free || !has_result);
   assign req_ready = !in_valid_ff || advance;
   assign res_valid = advance && has_result;
   assign res       = decoded;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Input byte payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // Control and decoder state; a configuration reload wins
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         header_address_ff    <= '0;
         header_mode_ff       <= 1'b0;
         pending_parameter_ff <= acd_pkg::PARAM_NONE;
         node_address_ff      <= '0;
         address_locked_ff    <= 1'b0;
         strike_base_ff       <= '0;
         strike_scale_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            header_address_ff    <= header_address_in;
            header_mode_ff       <= header_mode_in;
            pending_parameter_ff <= pending_parameter_in;
         end
         if (load.load) begin
            node_address_ff   <= load.node_address;
            address_locked_ff <= load.address_locked;
            strike_base_ff    <= load.strike_base;
            strike_scale_ff   <= load.strike_scale;
         end else if (advance) begin
            node_address_ff   <= node_address_in;
            address_locked_ff <= address_locked_in;
            strike_base_ff    <= strike_base_in;
            strike_scale_ff   <= strike_scale_in;
         end
      end
   end

   // Lock is sticky between reloads
   `ACD_ASSERT_NEXT(a_lock_sticky, clock, reset, address_locked_ff && !load.load, address_locked_ff)
   // Locked address never changes between reloads
   `ACD_ASSERT_NEXT(a_addr_held, clock, reset, address_locked_ff && !load.load, $stable(node_address_ff))
   // Headers never produce a result
   `ACD_ASSERT_SAME(a_header_silent, clock, reset, res_valid, !in_byte_ff[7])
   // Never push a result into a full output register
   `ACD_ASSERT_SAME(a_no_overrun, clock, reset, res_valid, out_free)

endmodule

/* sv/acd_rsp_reg.sv */
// ----------------------------------------------------------------------------
// Addressed actuator command decoder result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module acd_rsp_reg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          res_valid,
   input  acd_pkg::result_type           res,
   output logic                          out_free,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_action,
   output logic [acd_pkg::DUR_W-1:0]     rsp_duration,
   output logic [acd_pkg::ADDR_W-1:0]    rsp_saved_address,
   output logic [acd_pkg::DUR_W-1:0]     rsp_commit_base,
   output logic [acd_pkg::DUR_W-1:0]     rsp_commit_scale
);

   logic                rsp_valid_ff, rsp_valid_in;
   acd_pkg::result_type rsp_data_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_action        = rsp_data_ff.action;
   assign rsp_duration      = rsp_data_ff.duration;
   assign rsp_saved_address = rsp_data_ff.saved_address;
   assign rsp_commit_base   = rsp_data_ff.commit_base;
   assign rsp_commit_scale  = rsp_data_ff.commit_scale;

endmodule

/* sv/addressed_actuator_command_decoder.sv */
// ----------------------------------------------------------------------------
// Addressed actuator command decoder
// Decodes addressed serial command bytes into strike, damp, save and commit
// actions for one actuator node.
//
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_ready   rx_byte
// rsp_      out        rsp_valid/rsp_ready   action, duration, saved_address,
//                                            commit_base, commit_scale
// csr_      in         csr_valid/csr_ready   csr_index, csr_data
//
// One byte per cycle unless a waiting result stalls it; the byte is held in the
// input register, then its result in the result register that drives rsp_valid.
// Synchronous reset clears the stored registers and all decoder state.
// A waiting result stalls only bytes that produce a result; headers and
// silent bytes still drain. csr_ready is always high.
// ----------------------------------------------------------------------------
module addressed_actuator_command_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [acd_pkg::BYTE_W-1:0]    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_action,
   output logic [acd_pkg::DUR_W-1:0]     rsp_duration,
   output logic [acd_pkg::ADDR_W-1:0]    rsp_saved_address,
   output logic [acd_pkg::DUR_W-1:0]     rsp_commit_base,
   output logic [acd_pkg::DUR_W-1:0]     rsp_commit_scale,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [acd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [acd_pkg::CSR_DAT_W-1:0] csr_data
);

   acd_pkg::load_type   load;
   acd_pkg::result_type res;
   logic                res_valid;
   logic                out_free;

   acd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .load      (load)
   );

   acd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .load        (load),
      .out_free    (out_free),
      .res_valid   (res_valid),
      .res         (res)
   );

   acd_rsp_reg u_rsp_reg (
      .clock             (clock),
      .reset             (reset),
      .res_valid         (res_valid),
      .res               (res),
      .out_free          (out_free),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_action        (rsp_action),
      .rsp_duration      (rsp_duration),
      .rsp_saved_address (rsp_saved_address),
      .rsp_commit_base   (rsp_commit_base),
      .rsp_commit_scale  (rsp_commit_scale)
   );

endmodule
